[sv/fos_pkg.sv]
// Shared types and constants for the frequency order sorter.
// No dependencies; used by fos_ctrl, fos_datapath and the top level.
package fos_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last_item;
	} item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_result;
		logic               overflow;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T_RD,
		ST_T_CAP,
		ST_T_SCAN,
		ST_T_DRAIN,
		ST_T_WR,
		ST_S_INIT,
		ST_S_SCAN,
		ST_S_DRAIN,
		ST_S_RD,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic load;       // write accepted word into the value store
		logic tally_init; // restart outer tally index and emitted total
		logic rd_vi;      // read value[i]
		logic cap_vi;     // latch value[i], restart inner scan
		logic tscan;      // tally scan: read value[k]
		logic twr;        // write count[i], advance i
		logic sel_init;   // restart selection scan
		logic sscan;      // selection scan: read count[k]
		logic rd_best;    // read value[best], load repeat counter
		logic emit;       // drive one result word
		logic clr_best;   // zero count[best] and restart selection scan
	} cmd_t;

	typedef struct packed {
		logic k_last;   // scan index is at the last held entry
		logic i_last;   // tally index is at the last held entry
		logic rem_one;  // one repeat of the current value left
		logic all_done; // current word is the final one of the set
	} stat_t;

endpackage

[sv/fos_ctrl.sv]
// Sequencer for the frequency order sorter: load, tally, select, emit.
// Depends on fos_pkg; drives fos_datapath through cmd_t, reads stat_t.
module fos_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last_item,
	input  fos_pkg::stat_t stat,
	output fos_pkg::cmd_t  cmd,
	output logic          busy
);

	fos_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fos_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			fos_pkg::ST_IDLE: begin
				if (start && last_item) state_nx = fos_pkg::ST_T_RD;
			end
			fos_pkg::ST_T_RD:    state_nx = fos_pkg::ST_T_CAP;
			fos_pkg::ST_T_CAP:   state_nx = fos_pkg::ST_T_SCAN;
			fos_pkg::ST_T_SCAN: begin
				if (stat.k_last) state_nx = fos_pkg::ST_T_DRAIN;
			end
			fos_pkg::ST_T_DRAIN: state_nx = fos_pkg::ST_T_WR;
			fos_pkg::ST_T_WR: begin
				state_nx = stat.i_last ? fos_pkg::ST_S_INIT : fos_pkg::ST_T_RD;
			end
			fos_pkg::ST_S_INIT:  state_nx = fos_pkg::ST_S_SCAN;
			fos_pkg::ST_S_SCAN: begin
				if (stat.k_last) state_nx = fos_pkg::ST_S_DRAIN;
			end
			fos_pkg::ST_S_DRAIN: state_nx = fos_pkg::ST_S_RD;
			fos_pkg::ST_S_RD:    state_nx = fos_pkg::ST_EMIT;
			fos_pkg::ST_EMIT: begin
				if (stat.all_done) state_nx = fos_pkg::ST_IDLE;
				else if (stat.rem_one) state_nx = fos_pkg::ST_CLEAR;
			end
			fos_pkg::ST_CLEAR:   state_nx = fos_pkg::ST_S_SCAN;
			default:             state_nx = fos_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			fos_pkg::ST_IDLE: begin
				busy           = 1'b0;
				cmd.load       = start;
				cmd.tally_init = start && last_item;
			end
			fos_pkg::ST_T_RD:    cmd.rd_vi    = 1'b1;
			fos_pkg::ST_T_CAP:   cmd.cap_vi   = 1'b1;
			fos_pkg::ST_T_SCAN:  cmd.tscan    = 1'b1;
			fos_pkg::ST_T_DRAIN: cmd          = '0;
			fos_pkg::ST_T_WR:    cmd.twr      = 1'b1;
			fos_pkg::ST_S_INIT:  cmd.sel_init = 1'b1;
			fos_pkg::ST_S_SCAN:  cmd.sscan    = 1'b1;
			fos_pkg::ST_S_DRAIN: cmd          = '0;
			fos_pkg::ST_S_RD:    cmd.rd_best  = 1'b1;
			fos_pkg::ST_EMIT:    cmd.emit     = 1'b1;
			fos_pkg::ST_CLEAR:   cmd.clr_best = 1'b1;
			default:             cmd          = '0;
		endcase
	end

endmodule

[sv/fos_datapath.sv]
// Datapath for the frequency order sorter: value and count stores, scan
// counters, compare logic and the result register. Depends on fos_pkg.
module fos_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  fos_pkg::cmd_t    cmd,
	input  fos_pkg::item_t   item,
	output fos_pkg::stat_t   stat,
	output logic             strobe,
	output fos_pkg::result_t result
);

	logic [31:0]   vmem [fos_pkg::MAX_ITEMS];
	fos_pkg::cnt_t cmem [fos_pkg::MAX_ITEMS];

	logic [31:0]   vrd_q;
	fos_pkg::cnt_t crd_q;
	logic [31:0]   vi_q;

	fos_pkg::cnt_t load_cnt_q;
	logic          ovf_q;
	fos_pkg::idx_t i_q, k_q, best_q, k_s1;
	logic          tv_s1, sv_s1;
	fos_pkg::cnt_t cnt_q, best_cnt_q, rem_q, tot_q;
	logic          dup_q;
	logic          strobe_q;
	fos_pkg::result_t result_q;

	fos_pkg::cnt_t held_m1;
	fos_pkg::idx_t vraddr;
	fos_pkg::idx_t cwaddr;
	fos_pkg::cnt_t cwdata;
	logic          cwe;
	logic          vwe;
	logic          v_eq;
	logic          all_done;

	assign held_m1  = fos_pkg::CNT_W'(load_cnt_q - 1'b1);
	assign vwe      = cmd.load && (load_cnt_q < fos_pkg::CNT_W'(fos_pkg::MAX_ITEMS));
	// value[best] stays on the read port for every repeat of the current value
	assign vraddr   = cmd.rd_vi ? i_q : ((cmd.rd_best || cmd.emit) ? best_q : k_q);
	assign cwe      = cmd.twr || cmd.clr_best;
	assign cwaddr   = cmd.twr ? i_q : best_q;
	assign cwdata   = (cmd.twr && !dup_q) ? cnt_q : '0;
	assign v_eq     = (vrd_q == vi_q);
	assign all_done = (fos_pkg::CNT_W'(tot_q + 1'b1) == load_cnt_q);

	assign stat.k_last   = ({1'b0, k_q} == held_m1);
	assign stat.i_last   = ({1'b0, i_q} == held_m1);
	assign stat.rem_one  = (rem_q == fos_pkg::CNT_W'(1));
	assign stat.all_done = all_done;

	// stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (vwe) vmem[load_cnt_q[fos_pkg::IDX_W-1:0]] <= item.value;
		vrd_q <= vmem[vraddr];
	end

	always_ff @(posedge clk) begin
		if (cwe) cmem[cwaddr] <= cwdata;
		crd_q <= cmem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			ovf_q      <= 1'b0;
			tv_s1      <= 1'b0;
			sv_s1      <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			if (vwe) load_cnt_q <= fos_pkg::CNT_W'(load_cnt_q + 1'b1);
			else if (cmd.load) ovf_q <= 1'b1;
			// set is drained after the final word
			if (cmd.emit && all_done) begin
				load_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end
			tv_s1    <= cmd.tscan;
			sv_s1    <= cmd.sscan;
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q;
		if (cmd.tally_init) begin
			i_q   <= '0;
			tot_q <= '0;
		end
		if (cmd.twr) i_q <= fos_pkg::IDX_W'(i_q + 1'b1);
		if (cmd.cap_vi) begin
			vi_q  <= vrd_q;
			k_q   <= '0;
			cnt_q <= '0;
			dup_q <= 1'b0;
		end
		if (cmd.sel_init || cmd.clr_best) begin
			k_q        <= '0;
			best_cnt_q <= '0;
			best_q     <= '0;
		end
		if (cmd.tscan || cmd.sscan) k_q <= fos_pkg::IDX_W'(k_q + 1'b1);
		// count matches of value[i]; an earlier match means i is not a first occurrence
		if (tv_s1 && v_eq) begin
			cnt_q <= fos_pkg::CNT_W'(cnt_q + 1'b1);
			if (k_s1 < i_q) dup_q <= 1'b1;
		end
		// strict compare keeps the earliest index on equal counts
		if (sv_s1 && (crd_q > best_cnt_q)) begin
			best_cnt_q <= crd_q;
			best_q     <= k_s1;
		end
		if (cmd.rd_best) rem_q <= best_cnt_q;
		if (cmd.emit) begin
			rem_q                 <= fos_pkg::CNT_W'(rem_q - 1'b1);
			tot_q                 <= fos_pkg::CNT_W'(tot_q + 1'b1);
			result_q.sorted_value <= vrd_q;
			result_q.last_result  <= all_done;
			result_q.overflow     <= ovf_q;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

[sv/frequency_order_sorter_unit.sv]
// Frequency order sorter: words are loaded one per cycle (start high, busy
// low) until a word with last_item set. The block then goes busy and emits
// the whole set again, most frequent values first, ties by first occurrence.
// Each result word is on result for exactly one cycle, marked by strobe; the
// receiver cannot stall it. Tallying makes one inner scan of the value store
// per held entry (single read port), and each distinct value then costs one
// scan of the count store before its words are emitted. A set holds up to
// MAX_ITEMS (64) words; further words are dropped and overflow is set on
// every result of that set.
// Depends on fos_pkg, fos_ctrl and fos_datapath.
module frequency_order_sorter_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  fos_pkg::item_t   item,
	output logic             strobe,
	output fos_pkg::result_t result
);

	fos_pkg::cmd_t  cmd;
	fos_pkg::stat_t stat;

	fos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_item (item.last_item),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	fos_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule

[tb/frequency_order_sorter_unit_tb.sv]
// Testbench for frequency_order_sorter_unit: loads word sets, predicts the
// frequency-ordered output and checks every result word as it is strobed.
// Depends on fos_pkg and the frequency_order_sorter_unit RTL.
module frequency_order_sorter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fos_pkg::*;

	typedef struct packed {
		item_t w;
		logic  drain; // hold this word back until all expected results are in
	} pending_word_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    strobe;
	result_t result;

	pending_word_t word_queue[$];
	result_t       sorted_expect[$];

	// predictor state
	logic signed [31:0] held_vals [MAX_ITEMS];
	int                 n_held = 0;
	bit                 dropped = 1'b0;

	int n_taken = 0, n_seen = 0;
	int burst_left = 0, gap_left = 0;
	int mismatches = 0, results_checked = 0, sets_sorted = 0, overflow_sets = 0;
	int random_words = 0;

	frequency_order_sorter_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always #4 clk = ~clk;

	// Store an accepted word; on the last word of a set, count occurrences at
	// the first position of each value and queue the ranked output.
	task automatic load_and_rank(input item_t w);
		int      tally [MAX_ITEMS];
		int      j, top, top_cnt, emitted;
		result_t r;
		if (n_held < MAX_ITEMS) begin
			held_vals[n_held] = w.value;
			n_held++;
		end else begin
			dropped = 1'b1;
		end
		if (w.last_item) begin
			for (int i = 0; i < n_held; i++)
				tally[i] = 0;
			for (int i = 0; i < n_held; i++) begin
				j = 0;
				while (held_vals[j] != held_vals[i])
					j++;
				tally[j]++;
			end
			emitted = 0;
			top = 0;
			while (top >= 0) begin
				top = -1;
				top_cnt = 0;
				// strict compare keeps the earliest first occurrence on ties
				for (int k = 0; k < n_held; k++) begin
					if (tally[k] > top_cnt) begin
						top_cnt = tally[k];
						top = k;
					end
				end
				if (top >= 0) begin
					repeat (top_cnt) begin
						emitted++;
						r.sorted_value = held_vals[top];
						r.overflow = dropped;
						r.last_result = (emitted == n_held);
						sorted_expect.push_back(r);
					end
					tally[top] = 0;
				end
			end
			sets_sorted++;
			if (dropped)
				overflow_sets++;
			n_held = 0;
			dropped = 1'b0;
		end
	endtask

	task automatic queue_word(input logic [31:0] v, input bit last, input bit drain);
		pending_word_t p;
		p.w.value = v;
		p.w.last_item = last;
		p.drain = drain;
		word_queue.push_back(p);
	endtask

	// Values are drawn from a small pool so that repeats and ties are common.
	task automatic queue_random_set(input int n, input bit drain);
		logic [31:0] pool [MAX_ITEMS];
		int          pool_n;
		pool_n = $urandom_range(1, (n > MAX_ITEMS) ? MAX_ITEMS : n);
		for (int i = 0; i < pool_n; i++) begin
			case ($urandom_range(0, 15))
				0:       pool[i] = 32'h8000_0000;
				1:       pool[i] = 32'h7fff_ffff;
				2:       pool[i] = 32'h0;
				3:       pool[i] = 32'hffff_ffff;
				default: pool[i] = $urandom;
			endcase
		end
		for (int i = 0; i < n; i++)
			queue_word(pool[$urandom_range(0, pool_n - 1)], i == n - 1, drain && i == 0);
		random_words += n;
	endtask

	// driver: one word at a time, held until taken, in bursts with gaps
	always @(negedge clk) begin : drive
		logic          go;
		pending_word_t nxt;
		go = start;
		if (start && n_taken != n_seen) begin
			n_seen = n_taken;
			go = 1'b0;
		end
		if (!go && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (word_queue.size() > 0 &&
					!(word_queue[0].drain && sorted_expect.size() > 0)) begin
				nxt = word_queue.pop_front();
				item <= nxt.w;
				go = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		start <= go;
	end

	// monitor: check strobed words, then feed accepted words to the predictor
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (strobe) begin
				if (sorted_expect.size() == 0) begin
					$error("unexpected result word: sorted_value %0d", result.sorted_value);
					mismatches++;
				end else begin
					want = sorted_expect.pop_front();
					results_checked++;
					if (result.sorted_value !== want.sorted_value) begin
						$error("sorted_value: expected %0d, got %0d",
							want.sorted_value, result.sorted_value);
						mismatches++;
					end
					if (result.last_result !== want.last_result) begin
						$error("last_result: expected %0b, got %0b",
							want.last_result, result.last_result);
						mismatches++;
					end
					if (result.overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b",
							want.overflow, result.overflow);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				load_and_rank(item);
				n_taken++;
			end
		end
	end

	initial begin : stimulus
		int n, roll, total;
		// directed: extremes, heavier value seen later, count ties, one value,
		// all distinct, alternating bit patterns
		queue_word(32'h8000_0000, 1, 0);
		queue_word(32'h7fff_ffff, 1, 0);
		queue_word(32'h0, 0, 0);
		queue_word(32'hffff_ffff, 0, 0);
		queue_word(32'h0, 0, 0);
		queue_word(32'hffff_ffff, 0, 0);
		queue_word(32'hffff_ffff, 1, 0);
		queue_word(32'd5, 0, 0);
		queue_word(32'd7, 0, 0);
		queue_word(32'd5, 0, 0);
		queue_word(32'd7, 0, 0);
		queue_word(32'd9, 1, 0);
		queue_word(32'd3, 0, 1);
		queue_word(32'd3, 0, 0);
		queue_word(32'd3, 1, 0);
		queue_word(32'd1, 0, 0);
		queue_word(32'd2, 0, 0);
		queue_word(32'd3, 0, 0);
		queue_word(32'd4, 1, 0);
		queue_word(32'h5555_5555, 0, 0);
		queue_word(32'haaaa_aaaa, 0, 0);
		queue_word(32'haaaa_aaaa, 1, 0);

		// a full set and an overflowing one, then a random mix, mostly small
		queue_random_set(MAX_ITEMS, 1);
		queue_random_set($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8), 0);
		while (random_words < 480) begin
			roll = $urandom_range(0, 99);
			if (roll < 80)
				n = $urandom_range(1, 8);
			else if (roll < 92)
				n = $urandom_range(9, 40);
			else if (roll < 96)
				n = MAX_ITEMS;
			else
				n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
			queue_random_set(n, $urandom_range(0, 7) == 0);
		end
		total = word_queue.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_taken < total)
			@(posedge clk);
		while (sorted_expect.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("loaded %0d words in %0d sets (%0d with dropped words)",
			total, sets_sorted, overflow_sets);
		$display("checked %0d result words, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("frequency_order_sorter_unit test passed");
		else
			$display("frequency_order_sorter_unit test failed");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("timeout: %0d result words still expected", sorted_expect.size());
		$display("frequency_order_sorter_unit test failed");
		$finish;
	end

endmodule

[sim.f]
sv/fos_pkg.sv
sv/fos_ctrl.sv
sv/fos_datapath.sv
sv/frequency_order_sorter_unit.sv
tb/frequency_order_sorter_unit_tb.sv
